// File: hw/rtl/esr_pkg.sv
// shared constants, widths, register indexes and control structs for the
// ellipse scanline rasterizer; no dependencies
package esr_pkg;

    localparam int MAX_IMAGE_DIM  = 2048;
    localparam int MAX_RADIUS_Y   = 64;
    localparam int SQRT_FRAC_BITS = 8;

    // field widths
    localparam int CX_W  = 13;
    localparam int RX_W  = 11;
    localparam int RY_W  = 7;
    localparam int DIM_W = 12;
    localparam int COL_W = 11;

    // signed working width for rows and columns
    localparam int SW = CX_W + 2;

    // square root and divider sizing
    localparam int ROOT_W     = RY_W + SQRT_FRAC_BITS;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int PROD_W     = ROOT_W + RX_W;
    localparam int DIV_STEPS  = RX_W;
    localparam int DSH_W      = ROOT_W + DIV_STEPS - 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int MAX_STEPS  = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
    localparam int CNT_W      = $clog2(MAX_STEPS);

    // stream widths
    localparam int IN_W   = 48;
    localparam int OUT_W  = 48;
    localparam int USER_W = 2;

    // configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [DIM_W-1:0]     DIM_RESET        = 12'd256;

    typedef struct packed {
        logic load;
        logic next_dy;
        logic sqrt_init;
        logic sqrt_step;
        logic mul;
        logic div_step;
        logic keep_new;
        logic push_pend;
        logic push_final;
    } esr_cmd_t;

    typedef struct packed {
        logic dy_done;
        logic row_vis;
        logic span_ok;
        logic pend_have;
        logic out_free;
    } esr_stat_t;

endpackage

// File: hw/rtl/esr_ctrl.sv
// sequencing state machine of the ellipse scanline rasterizer
// depends on esr_pkg for the command and status structs and step counts
module esr_ctrl
    import esr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  esr_stat_t stat,
    output esr_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROW    = 3'd1;
    localparam logic [2:0] ST_SQRT   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_CLIP   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                if (stat.dy_done) begin
                    state_next = ST_FINISH;
                end else if (!stat.row_vis) begin
                    cmd.next_dy = 1'b1;
                end else begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = CNT_W'(SQRT_STEPS - 1);
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_CLIP;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CLIP: begin
                // a new span can only replace the held one once that one has left
                if (!stat.span_ok) begin
                    cmd.next_dy = 1'b1;
                    state_next  = ST_ROW;
                end else if (!stat.pend_have || stat.out_free) begin
                    cmd.keep_new  = 1'b1;
                    cmd.push_pend = stat.pend_have;
                    cmd.next_dy   = 1'b1;
                    state_next    = ST_ROW;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.push_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/esr_datapath.sv
// datapath of the ellipse scanline rasterizer: canvas registers, row test,
// bit-serial square root, radius scaling divider, clipping and result registers
// depends on esr_pkg
module esr_datapath
    import esr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    output logic [USER_W-1:0]    m_tuser,
    output logic                 m_tlast,
    input  esr_cmd_t             cmd,
    output esr_stat_t            stat
);

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;

    // ellipse and row counter
    logic signed [CX_W-1:0] cx_reg, cy_reg;
    logic [RX_W-1:0]        rx_reg;
    logic [RY_W-1:0]        ry_reg, dy_reg;
    logic [RY_W-1:0]        ry_in;

    // square root
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  srem_reg;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              sqrt_ge;
    logic [2*RY_W-1:0] rad_diff;

    // divider
    logic [PROD_W-1:0] drem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [COL_W-1:0]  quo_reg;
    logic              div_ge;

    // held and outgoing results
    logic             pend_have_reg;
    logic [COL_W-1:0] pu_row_reg, pl_row_reg, pxs_reg, pxe_reg;
    logic             pu_v_reg, pl_v_reg;
    logic             out_valid_reg;
    logic [COL_W-1:0] ou_row_reg, ol_row_reg, oxs_reg, oxe_reg;
    logic             ou_v_reg, ol_v_reg, olast_reg;

    // row and span logic
    logic [DIM_W+1:0]     w_eff, h_eff;
    logic signed [SW-1:0] cx_ext, cy_ext, dy_ext, w_ext, h_ext, s_ext;
    logic signed [SW-1:0] y1, y2, x1, x2, x1c, x2c;
    logic                 v1, v2;
    logic                 out_free;

    // out-of-range canvas sizes clamp to 1..MAX_IMAGE_DIM
    always_comb begin
        if (width_reg == '0) begin
            w_eff = (DIM_W+2)'(1);
        end else if (width_reg > MAX_IMAGE_DIM) begin
            w_eff = (DIM_W+2)'(MAX_IMAGE_DIM);
        end else begin
            w_eff = (DIM_W+2)'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = (DIM_W+2)'(1);
        end else if (height_reg > MAX_IMAGE_DIM) begin
            h_eff = (DIM_W+2)'(MAX_IMAGE_DIM);
        end else begin
            h_eff = (DIM_W+2)'(height_reg);
        end
    end

    assign ry_in = s_tdata[43:37];

    assign cx_ext = SW'(cx_reg);
    assign cy_ext = SW'(cy_reg);
    assign dy_ext = SW'($signed({1'b0, dy_reg}));
    assign w_ext  = SW'($signed({1'b0, w_eff}));
    assign h_ext  = SW'($signed({1'b0, h_eff}));
    assign s_ext  = SW'($signed({1'b0, quo_reg}));

    assign y1 = cy_ext - dy_ext;
    assign y2 = cy_ext + dy_ext;
    assign v1 = (y1 >= 0) && (y1 < h_ext);
    assign v2 = (y2 >= 0) && (y2 < h_ext) && (dy_reg != '0);

    assign x1  = cx_ext - s_ext;
    assign x2  = cx_ext + s_ext;
    assign x1c = (x1 < 0) ? '0 : x1;
    assign x2c = (x2 > w_ext - SW'(1)) ? w_ext - SW'(1) : x2;

    assign out_free = !out_valid_reg || m_tready;

    assign stat.dy_done   = (dy_reg >= ry_reg);
    assign stat.row_vis   = v1 || v2;
    assign stat.span_ok   = (x1c <= x2c);
    assign stat.pend_have = pend_have_reg;
    assign stat.out_free  = out_free;

    // one root bit per cycle, two radicand bits shifted in
    assign rad_diff = (ry_reg * ry_reg) - (dy_reg * dy_reg);
    assign rem_sh   = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign sqrt_ge  = (rem_sh >= trial);

    // restoring divide by ry << SQRT_FRAC_BITS, one quotient bit per cycle
    assign div_ge = (PROD_W'(dsh_reg) <= drem_reg);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= $signed(s_tdata[12:0]);
            cy_reg <= $signed(s_tdata[25:13]);
            rx_reg <= s_tdata[36:26];
            ry_reg <= (ry_in > MAX_RADIUS_Y) ? RY_W'(MAX_RADIUS_Y) : ry_in;
            dy_reg <= '0;
        end else if (cmd.next_dy) begin
            dy_reg <= dy_reg + 1'b1;
        end

        if (cmd.sqrt_init) begin
            rad_reg  <= RAD_W'(rad_diff) << (2 * SQRT_FRAC_BITS);
            root_reg <= '0;
            srem_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= rad_reg << 2;
            root_reg <= {root_reg[ROOT_W-2:0], sqrt_ge};
            srem_reg <= sqrt_ge ? rem_sh - trial : rem_sh;
        end

        if (cmd.mul) begin
            drem_reg <= root_reg * rx_reg;
            dsh_reg  <= DSH_W'(ry_reg) << (SQRT_FRAC_BITS + DIV_STEPS - 1);
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            if (div_ge) begin
                drem_reg <= drem_reg - PROD_W'(dsh_reg);
            end
            quo_reg <= {quo_reg[COL_W-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end

        if (cmd.keep_new) begin
            pu_row_reg <= v1 ? y1[COL_W-1:0] : '0;
            pu_v_reg   <= v1;
            pl_row_reg <= v2 ? y2[COL_W-1:0] : '0;
            pl_v_reg   <= v2;
            pxs_reg    <= x1c[COL_W-1:0];
            pxe_reg    <= x2c[COL_W-1:0];
        end

        if (cmd.push_pend || (cmd.push_final && pend_have_reg)) begin
            ou_row_reg <= pu_row_reg;
            ou_v_reg   <= pu_v_reg;
            ol_row_reg <= pl_row_reg;
            ol_v_reg   <= pl_v_reg;
            oxs_reg    <= pxs_reg;
            oxe_reg    <= pxe_reg;
            olast_reg  <= cmd.push_final;
        end else if (cmd.push_final) begin
            // nothing visible: a single empty result closes the ellipse
            ou_row_reg <= '0;
            ou_v_reg   <= 1'b0;
            ol_row_reg <= '0;
            ol_v_reg   <= 1'b0;
            oxs_reg    <= '0;
            oxe_reg    <= '0;
            olast_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                pend_have_reg <= 1'b0;
            end else if (cmd.keep_new) begin
                pend_have_reg <= 1'b1;
            end
            if (cmd.push_pend || cmd.push_final) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, oxe_reg, oxs_reg, ol_row_reg, ou_row_reg};
    assign m_tuser  = {ol_v_reg, ou_v_reg};
    assign m_tlast  = olast_reg;

    // a result is never written over one that has not left
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_pend || cmd.push_final) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before delivery");

    // the square root never exceeds ry with its fraction bits
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (root_reg <= (ROOT_W'(ry_reg) << SQRT_FRAC_BITS)))
        else $error("square root above vertical radius");

    // the scaled half-width never exceeds the horizontal radius
    a_half_width: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.keep_new |-> (quo_reg <= rx_reg))
        else $error("half-width above horizontal radius");

    // a span is only held when it is on the canvas
    a_keep_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.keep_new |-> (stat.span_ok && (v1 || v2)))
        else $error("invisible span kept");

endmodule

// File: hw/rtl/ellipse_scanline_rasterizer.sv
// top level of the ellipse scanline rasterizer: joins the controller and
// the datapath; depends on esr_pkg, esr_ctrl and esr_datapath
//
// usage:
//   s_ channel: one beat per ellipse. s_tready is high only while no ellipse
//   is being rasterized; the last result may still wait at the m_ side.
//   m_ channel: one beat per visible span pair, m_tlast on the final one.
//   an ellipse with nothing on the canvas gives one beat with all fields and
//   flags zero and m_tlast set.
//   cfg_ channel: index 0 image width, index 1 image height, always ready;
//   other indexes are ignored. write only while idle.
// sequencing:
//   a row offset whose rows miss the canvas is skipped by the row test; a visible
//   one runs the one-bit-per-cycle square root, a multiply, the one-bit-per-cycle
//   divider and the clip step. the ellipse is accepted while idle and closed by a
//   finish step; one ellipse at a time.
// stalls and reset:
//   one span is held back until the next is known, so a stalled m_ side only
//   stops the sequence when the result register and the held span are both
//   full and a further span is ready; closing also waits for the m_ side.
//   reset (aresetn low, synchronous) empties the block and sets both canvas
//   registers to 256.
module ellipse_scanline_rasterizer
    import esr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // center_x[12:0], center_y[25:13], radius_x[36:26], radius_y[43:37], zero pad
    input  logic [IN_W-1:0]      s_tdata,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // row_upper[10:0], row_lower[21:11], span_start[32:22], span_end[43:33], zero pad
    output logic [OUT_W-1:0]     m_tdata,
    // upper_valid[0], lower_valid[1]
    output logic [USER_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    esr_cmd_t  cmd;
    esr_stat_t stat;

    esr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    esr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
